### rtl/btp_pkg.sv
`default_nettype none

package btp_pkg;

  // Address width walked by the trie, most significant bit first
  localparam int ADDR_BITS = 32;
  // Width of a depth count, 0 to ADDR_BITS inclusive
  localparam int DEPTH_W = $clog2(ADDR_BITS + 1);
  // Prefix length port width
  localparam int PLEN_W = 6;
  // Default size of the node store
  localparam int NODE_COUNT_DEF = 4096;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Finished result offered by the walker to the output stage
  typedef struct packed {
    logic                 valid;
    logic [DEPTH_W-1:0]   match_len;
    logic [ADDR_BITS-1:0] matched_prefix;
    logic                 found;
    logic                 pool_full;
  } walk_res_t;

endpackage

`default_nettype wire

### rtl/btp_node_mem.sv
`default_nettype none

module btp_node_mem
  import btp_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  localparam int LINK_W = $clog2(NODE_COUNT)
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [LINK_W-1:0]   waddr,
  input  wire logic [2*LINK_W-1:0] wdata,
  input  wire logic [LINK_W-1:0]   raddr,
  output logic      [2*LINK_W-1:0] rdata
);

  // Child links per node: upper half is the one child, lower half the zero child
  logic [2*LINK_W-1:0] mem [NODE_COUNT];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/btp_walk.sv
`default_nettype none

module btp_walk
  import btp_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  localparam int LINK_W = $clog2(NODE_COUNT),
  localparam int FREE_W = $clog2(NODE_COUNT + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 command,
  input  wire logic [ADDR_BITS-1:0] address,
  input  wire logic [PLEN_W-1:0]    prefix_len,
  output walk_res_t                 res,
  input  wire logic                 res_take,
  output logic                      mem_we,
  output logic      [LINK_W-1:0]    mem_waddr,
  output logic      [2*LINK_W-1:0]  mem_wdata,
  output logic      [LINK_W-1:0]    mem_raddr,
  input  wire logic [2*LINK_W-1:0]  mem_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_CHAIN, S_DONE} state_t;

  state_t               state;
  logic                 cmd;
  logic [ADDR_BITS-1:0] addr;
  logic [ADDR_BITS-1:0] sh;
  logic [ADDR_BITS-1:0] keep;
  logic [DEPTH_W-1:0]   limit;
  logic [DEPTH_W-1:0]   depth;
  logic [LINK_W-1:0]    node;
  logic [FREE_W-1:0]    free;
  logic [LINK_W-1:0]    root_zero;
  logic [LINK_W-1:0]    root_one;
  logic [DEPTH_W-1:0]   res_len;
  logic [ADDR_BITS-1:0] res_prefix;
  logic                 res_found;
  logic                 res_full;

  logic [LINK_W-1:0]    cur_zero;
  logic [LINK_W-1:0]    cur_one;
  logic                 bit_b;
  logic [LINK_W-1:0]    nxt;
  logic                 nxt_ok;
  logic                 pool_empty;
  logic [LINK_W-1:0]    free_link;
  logic                 at_limit;
  logic [DEPTH_W-1:0]   plen_sat;
  logic [DEPTH_W-1:0]   fin_len;
  logic [ADDR_BITS-1:0] fin_prefix;
  logic                 fin_found;

  // Links of the current node: root lives in registers, the rest in the store
  assign cur_zero   = (node == '0) ? root_zero : mem_rdata[LINK_W-1:0];
  assign cur_one    = (node == '0) ? root_one  : mem_rdata[2*LINK_W-1:LINK_W];
  assign bit_b      = sh[ADDR_BITS-1];
  assign nxt        = bit_b ? cur_one : cur_zero;
  assign nxt_ok     = (nxt != '0) && (32'(nxt) < 32'(NODE_COUNT));
  assign pool_empty = (32'(free) >= 32'(NODE_COUNT));
  assign free_link  = free[LINK_W-1:0];
  assign at_limit   = (depth == limit);

  // Saturate the prefix length at the address width
  assign plen_sat = (prefix_len > PLEN_W'(ADDR_BITS)) ? DEPTH_W'(ADDR_BITS)
                                                      : DEPTH_W'(prefix_len);

  // Result values when the walk stops at the current depth
  assign fin_len    = (cmd == CMD_SEARCH) ? depth : '0;
  assign fin_prefix = (cmd == CMD_SEARCH) ? (addr & keep) : '0;
  assign fin_found  = (cmd == CMD_SEARCH) && (depth != '0);

  assign in_stall = (state != S_IDLE);

  assign res.valid          = (state == S_DONE);
  assign res.match_len      = res_len;
  assign res.matched_prefix = res_prefix;
  assign res.found          = res_found;
  assign res.pool_full      = res_full;

  // Store accesses: read the next node, link a parent or fill a new node
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node;
    mem_wdata = '0;
    mem_raddr = nxt;
    unique case (state)
      S_WALK: begin
        if (!at_limit && !nxt_ok && cmd == CMD_INSERT && !pool_empty &&
            node != '0) begin
          mem_we    = 1'b1;
          mem_wdata = bit_b ? {free_link, cur_zero} : {cur_one, free_link};
        end
      end
      S_CHAIN: begin
        // A fresh node is always written once, with its single child or empty
        mem_we = 1'b1;
        if (!at_limit && !pool_empty) begin
          mem_wdata = bit_b ? {free_link, LINK_W'(0)} : {LINK_W'(0), free_link};
        end
      end
      default: begin
      end
    endcase
  end

  // Walk control, allocation counter and held result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free      <= FREE_W'(1);
      root_zero <= '0;
      root_one  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd   <= command;
            addr  <= address;
            sh    <= address;
            keep  <= '0;
            limit <= (command == CMD_SEARCH) ? DEPTH_W'(ADDR_BITS) : plen_sat;
            depth <= '0;
            node  <= '0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (at_limit) begin
            res_len    <= fin_len;
            res_prefix <= fin_prefix;
            res_found  <= fin_found;
            res_full   <= 1'b0;
            state      <= S_DONE;
          end else if (nxt_ok) begin
            // Follow an existing link
            node  <= nxt;
            depth <= depth + DEPTH_W'(1);
            sh    <= sh << 1;
            keep  <= {1'b1, keep[ADDR_BITS-1:1]};
          end else if (cmd == CMD_SEARCH) begin
            res_len    <= fin_len;
            res_prefix <= fin_prefix;
            res_found  <= fin_found;
            res_full   <= 1'b0;
            state      <= S_DONE;
          end else if (pool_empty) begin
            res_len    <= '0;
            res_prefix <= '0;
            res_found  <= 1'b0;
            res_full   <= 1'b1;
            state      <= S_DONE;
          end else begin
            // Link a new node under the current one and start the fresh chain
            if (node == '0) begin
              if (bit_b) begin
                root_one <= free_link;
              end else begin
                root_zero <= free_link;
              end
            end
            node  <= free_link;
            free  <= free + FREE_W'(1);
            depth <= depth + DEPTH_W'(1);
            sh    <= sh << 1;
            state <= S_CHAIN;
          end
        end
        S_CHAIN: begin
          if (at_limit || pool_empty) begin
            res_len    <= '0;
            res_prefix <= '0;
            res_found  <= 1'b0;
            res_full   <= !at_limit;
            state      <= S_DONE;
          end else begin
            node  <= free_link;
            free  <= free + FREE_W'(1);
            depth <= depth + DEPTH_W'(1);
            sh    <= sh << 1;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/binary_trie_prefix_insert_search.sv
`default_nettype none

// Binary trie of 32-bit addresses. An insert (command 0) walks the top
// prefix_len bits and takes new nodes from an allocation counter where a link
// is missing, reporting pool_full if the store runs dry; a search (command 1)
// follows links as deep as they go and returns the depth and masked address.
// One item is in work at a time. It walks one trie level after another, at
// most 32 levels, reading each next node through the registered read port of
// the node store, then settles the result and moves it into the output
// register. The input is free again in the same cycle that the result
// stands at the output. The next item can be taken while a result waits at
// the output, but while the output register is stalled a second finished
// result holds the walker and the input waits.
// Root links sit in registers and every other node is written when it is
// allocated, so no clearing pass follows reset.
module binary_trie_prefix_insert_search
  import btp_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 command,
  input  wire logic [ADDR_BITS-1:0] address,
  input  wire logic [PLEN_W-1:0]    prefix_len,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [DEPTH_W-1:0]   match_len,
  output logic      [ADDR_BITS-1:0] matched_prefix,
  output logic                      found,
  output logic                      pool_full
);

  localparam int LINK_W = $clog2(NODE_COUNT);

  walk_res_t           res;
  logic                res_take;
  logic                mem_we;
  logic [LINK_W-1:0]   mem_waddr;
  logic [2*LINK_W-1:0] mem_wdata;
  logic [LINK_W-1:0]   mem_raddr;
  logic [2*LINK_W-1:0] mem_rdata;

  btp_walk #(
    .NODE_COUNT(NODE_COUNT)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .address   (address),
    .prefix_len(prefix_len),
    .res       (res),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  btp_node_mem #(
    .NODE_COUNT(NODE_COUNT)
  ) u_node_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Take a finished result whenever the output register is free or draining
  assign res_take = res.valid && (!out_valid || !out_stall);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid      <= 1'b1;
      match_len      <= res.match_len;
      matched_prefix <= res.matched_prefix;
      found          <= res.found;
      pool_full      <= res.pool_full;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // A search result never reports a full pool
  a_found_not_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(found && pool_full))
    else $error("found and pool_full both set");

  // A match implies a non-zero depth, and no match leaves the prefix clear
  a_found_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found == (match_len != '0)))
    else $error("found disagrees with match_len");

  a_miss_prefix: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (matched_prefix == '0))
    else $error("prefix set without a match");

  // After a transfer in the walker is busy on the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice back to back");

endmodule

`default_nettype wire
